/* rtl/core/ble_mpp_pkg.sv */
package ble_mpp_pkg;

    localparam logic [7:0] C_SYSEX_START = 8'hF0;
    localparam logic [7:0] C_SYSEX_END   = 8'hF7;
    localparam logic [7:0] C_RT_FIRST    = 8'hF8;
    localparam logic [7:0] C_SONG_POS    = 8'hF2;
    localparam logic [7:0] C_MTC_QFRAME  = 8'hF1;
    localparam logic [7:0] C_SONG_SEL    = 8'hF3;
    localparam logic [3:0] C_SYS_NIBBLE  = 4'hF;
    localparam logic [3:0] C_PROG_CHG    = 4'hC;
    localparam logic [3:0] C_CH_PRESS    = 4'hD;

    localparam logic C_KIND_MSG = 1'b0;
    localparam logic C_KIND_RT  = 1'b1;

    typedef struct packed {
        logic        message_kind;
        logic [7:0]  status_byte;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [1:0]  message_length;
        logic [12:0] sender_time_ms;
        logic        sender_time_valid;
        logic [62:0] receive_time;
    } t_result;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        n = 2'd0;
        if (st[7]) begin
            if (st[7:4] == C_SYS_NIBBLE) begin
                if (st == C_MTC_QFRAME || st == C_SONG_SEL) begin
                    n = 2'd1;
                end else if (st == C_SONG_POS) begin
                    n = 2'd2;
                end
            end else if (st[7:4] == C_PROG_CHG || st[7:4] == C_CH_PRESS) begin
                n = 2'd1;
            end else begin
                n = 2'd2;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/core/ble_mpp_core.sv */
module ble_mpp_core
    import ble_mpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_of_packet,
    input  logic [62:0] i_rx_time,
    output logic        o_res_valid,
    output t_result     o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AFTER_TS,
        PH_COLLECT,
        PH_SYSEX_TS
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_sysex, n_sysex;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_pending, n_pending;
    logic [6:0]  r_first_data, n_first_data;
    logic [1:0]  r_left, n_left;
    logic [5:0]  r_high, n_high;
    logic [6:0]  r_last, n_last;
    logic        r_seen, n_seen;
    logic        r_ok, n_ok;

    logic        do_after, do_running, emit_msg, emit_rt;
    logic [7:0]  msg_st;
    logic [6:0]  msg_d1, msg_d2;
    logic [7:0]  b;
    logic [6:0]  low;
    logic [1:0]  need;

    always_comb begin
        b            = i_byte_value;
        low          = b[6:0];
        need         = data_count(b);
        n_phase      = r_phase;
        n_sysex      = r_sysex;
        n_running    = r_running;
        n_pending    = r_pending;
        n_first_data = r_first_data;
        n_left       = r_left;
        n_high       = r_high;
        n_last       = r_last;
        n_seen       = r_seen;
        n_ok         = r_ok;
        do_after     = 1'b0;
        do_running   = 1'b0;
        emit_msg     = 1'b0;
        emit_rt      = 1'b0;
        msg_st       = 8'd0;
        msg_d1       = 7'd0;
        msg_d2       = 7'd0;

        if (i_first_of_packet) begin
            if (r_phase == PH_SYSEX_TS) begin
                n_sysex = 1'b0;
            end
            n_phase = PH_IDLE;
            n_left  = 2'd0;
            if (!b[7]) begin
                n_ok = 1'b0;
            end else begin
                n_ok      = 1'b1;
                n_high    = b[5:0];
                n_seen    = 1'b0;
                n_last    = 7'd0;
                n_running = 8'd0;
            end
        end else if (r_ok) begin
            if (r_phase == PH_SYSEX_TS) begin
                n_phase = PH_IDLE;
                if (b == C_SYSEX_END) begin
                    n_sysex = 1'b0;
                end else if (b >= C_RT_FIRST) begin
                    emit_rt = 1'b1;
                end else begin
                    n_sysex  = 1'b0;
                    do_after = 1'b1;
                end
            end else if (r_sysex) begin
                if (b == C_SYSEX_END) begin
                    n_sysex = 1'b0;
                end else if (b >= C_RT_FIRST) begin
                    emit_rt = 1'b1;
                end else if (b[7]) begin
                    if (r_seen && low < r_last) begin
                        n_high = r_high + 6'd1;
                    end
                    n_seen  = 1'b1;
                    n_last  = low;
                    n_phase = PH_SYSEX_TS;
                end
            end else begin
                unique case (r_phase)
                    PH_AFTER_TS: begin
                        do_after = 1'b1;
                    end
                    PH_COLLECT: begin
                        if (r_left >= 2'd2) begin
                            n_first_data = low;
                            n_left       = 2'd1;
                        end else begin
                            n_left   = 2'd0;
                            emit_msg = 1'b1;
                            msg_st   = r_pending;
                            if (data_count(r_pending) == 2'd2) begin
                                msg_d1 = r_first_data;
                                msg_d2 = low;
                            end else begin
                                msg_d1 = low;
                            end
                        end
                    end
                    default: begin
                        if (b[7]) begin
                            if (r_seen && low < r_last) begin
                                n_high = r_high + 6'd1;
                            end
                            n_seen  = 1'b1;
                            n_last  = low;
                            n_phase = PH_AFTER_TS;
                        end else begin
                            do_running = 1'b1;
                        end
                    end
                endcase
            end
        end

        if (do_after) begin
            if (!b[7]) begin
                do_running = 1'b1;
            end else begin
                n_phase = PH_IDLE;
                if (b >= C_RT_FIRST) begin
                    emit_rt = 1'b1;
                end else if (b == C_SYSEX_START) begin
                    n_sysex = 1'b1;
                end else if (need == 2'd0) begin
                    emit_msg = 1'b1;
                    msg_st   = b;
                end else begin
                    n_pending = b;
                    n_left    = need;
                    n_phase   = PH_COLLECT;
                end
            end
        end

        if (do_running) begin
            if (r_running == 8'd0) begin
                n_phase = PH_IDLE;
            end else if (data_count(r_running) == 2'd1) begin
                emit_msg = 1'b1;
                msg_st   = r_running;
                msg_d1   = low;
            end else begin
                n_pending    = r_running;
                n_first_data = low;
                n_left       = 2'd1;
                n_phase      = PH_COLLECT;
            end
        end

        if (emit_msg) begin
            n_running = (msg_st[7:4] != C_SYS_NIBBLE) ? msg_st : 8'd0;
            n_phase   = PH_IDLE;
        end

        o_result = '0;
        if (emit_rt) begin
            o_result.message_kind      = C_KIND_RT;
            o_result.status_byte       = b;
            o_result.message_length    = 2'd1;
            o_result.sender_time_ms    = r_seen ? {r_high, r_last} : 13'd0;
            o_result.sender_time_valid = r_seen;
            o_result.receive_time      = i_rx_time;
        end else begin
            o_result.message_kind   = C_KIND_MSG;
            o_result.status_byte    = msg_st;
            o_result.data1          = msg_d1;
            o_result.data2          = msg_d2;
            o_result.message_length = 2'd1 + data_count(msg_st);
        end
        o_res_valid = i_en && (emit_msg || emit_rt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_sysex      <= 1'b0;
            r_running    <= 8'd0;
            r_pending    <= 8'd0;
            r_first_data <= 7'd0;
            r_left       <= 2'd0;
            r_high       <= 6'd0;
            r_last       <= 7'd0;
            r_seen       <= 1'b0;
            r_ok         <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_sysex      <= n_sysex;
            r_running    <= n_running;
            r_pending    <= n_pending;
            r_first_data <= n_first_data;
            r_left       <= n_left;
            r_high       <= n_high;
            r_last       <= n_last;
            r_seen       <= n_seen;
            r_ok         <= n_ok;
        end
    end

endmodule

/* rtl/core/ble_mpp_out_reg.sv */
module ble_mpp_out_reg
    import ble_mpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/ble_midi_packet_parser_top.sv */
// BLE-MIDI packet parser
// input channel: one packet byte per transaction (i_valid / o_stall), with
// i_first_of_packet marking the header byte and i_rx_time the receive time
// output channel: one decoded message or realtime byte per transaction
// (o_valid / i_stall); a byte produces zero or one result
// path: a taken byte is held in the input register, decoded by the core,
// and its result is registered in the result register that drives o_valid
// throughput: one byte per cycle while no result is stalled; the parser
// state update is one combinational step between input and result registers
// stall: while a result waits under i_stall the input register holds its
// byte and o_stall rises once that register is full; when the result
// register is empty or taken, a new byte enters every cycle
// reset: synchronous, active low; drops all pending transactions and
// clears the parser state, so bytes before the first header are ignored
module ble_midi_packet_parser_top
    import ble_mpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first_of_packet,
    input  logic [62:0] i_rx_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_message_kind,
    output logic [7:0]  o_status_byte,
    output logic [6:0]  o_data1,
    output logic [6:0]  o_data2,
    output logic [1:0]  o_message_length,
    output logic [12:0] o_sender_time_ms,
    output logic        o_sender_time_valid,
    output logic [62:0] o_receive_time
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_first;
    logic [62:0] r_rx_time;
    logic        out_ready, core_en, core_res_valid;
    t_result     core_result, out_result;

    assign o_stall = r_in_valid && !out_ready;
    assign core_en = r_in_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte    <= i_byte_value;
            r_first   <= i_first_of_packet;
            r_rx_time <= i_rx_time;
        end
    end

    ble_mpp_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (core_en),
        .i_byte_value      (r_byte),
        .i_first_of_packet (r_first),
        .i_rx_time         (r_rx_time),
        .o_res_valid       (core_res_valid),
        .o_result          (core_result)
    );

    ble_mpp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_res_valid),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_message_kind      = out_result.message_kind;
    assign o_status_byte       = out_result.status_byte;
    assign o_data1             = out_result.data1;
    assign o_data2             = out_result.data2;
    assign o_message_length    = out_result.message_length;
    assign o_sender_time_ms    = out_result.sender_time_ms;
    assign o_sender_time_valid = out_result.sender_time_valid;
    assign o_receive_time      = out_result.receive_time;

endmodule

/* rtl/core/ble_mpp_checker.sv */
module ble_mpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_message_kind,
    input logic [6:0]  o_data1,
    input logic [6:0]  o_data2,
    input logic [1:0]  o_message_length,
    input logic [12:0] o_sender_time_ms,
    input logic        o_sender_time_valid,
    input logic [62:0] o_receive_time
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled result dropped");

    a_rt_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_kind |->
            o_message_length == 2'd1 && o_data1 == 7'd0 && o_data2 == 7'd0)
        else $error("realtime result malformed");

    a_msg_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_message_kind |->
            !o_sender_time_valid && o_sender_time_ms == 13'd0 && o_receive_time == 63'd0
            && o_message_length != 2'd0)
        else $error("message result carries time");

    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sender_time_valid |-> o_sender_time_ms == 13'd0)
        else $error("sender time without timestamp");

endmodule

bind ble_midi_packet_parser_top ble_mpp_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_message_kind      (o_message_kind),
    .o_data1             (o_data1),
    .o_data2             (o_data2),
    .o_message_length    (o_message_length),
    .o_sender_time_ms    (o_sender_time_ms),
    .o_sender_time_valid (o_sender_time_valid),
    .o_receive_time      (o_receive_time)
);
